[rtl/core/kpt_pkg.sv]
package kpt_pkg;

    // default table depth
    localparam int ENTRIES_DEF = 64;

    localparam int KEY_W = 32;
    localparam int PRI_W = 8;
    localparam int SEQ_W = 32;

    typedef enum logic [1:0]
    {
        OP_INSERT   = 2'd0,
        OP_INCREASE = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_QUERY    = 2'd3
    } kpt_op_t;

    typedef enum logic [1:0]
    {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_MISSING = 2'd2,
        STATUS_EMPTY   = 2'd3
    } kpt_status_t;

    // request payload
    typedef struct packed
    {
        kpt_op_t            op;
        logic [KEY_W-1:0]   entry_key;
        logic [PRI_W-1:0]   amount;
    } kpt_req_t;

    // response payload
    typedef struct packed
    {
        kpt_status_t        status;
        logic [KEY_W-1:0]   best_key;
        logic [PRI_W-1:0]   best_priority;
    } kpt_rsp_t;

    // one table slot as held in memory
    typedef struct packed
    {
        logic               valid;
        logic [KEY_W-1:0]   id;
        logic [PRI_W-1:0]   pri;
        logic [SEQ_W-1:0]   seq;
    } kpt_rec_t;

endpackage

[rtl/core/keyed_priority_table.sv]
// keyed_priority_table: a table of ENTRIES keyed slots, each with a priority
// and an arrival stamp.
// request channel (req_valid/req_ready/req) carries op, entry_key and amount:
// insert, increase priority (saturating at 255), remove, or query best.
// response channel (rsp_valid/rsp_ready/rsp) returns exactly one response per
// request: status, and best_key/best_priority on a successful query.
// every request scans all slots through one compare unit, one slot a cycle
// off the registered read port of the slot memory; a new request is accepted
// only once the response to the previous one has been registered.
// the write-back of insert, increase and remove happens in the last cycle.
// after reset a clearing pass marks every slot free; req_ready stays low
// during it.
// a finished response waits in the output register; the next request is
// accepted and scanned meanwhile, but its response waits until the
// receiver has taken the previous one.
module keyed_priority_table
    import kpt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  kpt_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output kpt_rsp_t rsp
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    typedef enum logic [1:0]
    {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [IW-1:0]    cnt_reg, cnt_next;
    logic             issue_reg, issue_next;
    logic             d_valid_reg, d_valid_next;
    logic [IW-1:0]    d_idx_reg, d_idx_next;
    kpt_op_t          op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [PRI_W-1:0] amount_reg, amount_next;
    logic             found_reg, found_next;
    kpt_rec_t         best_reg, best_next;
    logic [IW-1:0]    best_idx_reg, best_idx_next;
    logic [SEQ_W-1:0] arrival_reg, arrival_next;
    logic             rsp_valid_reg, rsp_valid_next;
    kpt_rsp_t         rsp_reg, rsp_next;

    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    kpt_rec_t         mem_wdata;
    logic             mem_re;
    kpt_rec_t         mem_rdata;
    logic             take;
    logic [PRI_W:0]   pri_sum;

    // slot memory
    kpt_mem #(.DEPTH(ENTRIES)) u_mem
    (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (cnt_reg),
        .rd_data (mem_rdata)
    );

    // shared compare unit
    kpt_cmp u_cmp
    (
        .op    (op_reg),
        .key   (key_reg),
        .cand  (mem_rdata),
        .best  (best_reg),
        .found (found_reg),
        .take  (take)
    );

    assign pri_sum = {1'b0, best_reg.pri} + {1'b0, amount_reg};

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        issue_next     = issue_reg;
        d_valid_next   = 1'b0;
        d_idx_next     = d_idx_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        amount_next    = amount_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        arrival_next   = arrival_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = best_idx_reg;
        mem_wdata      = best_reg;
        mem_re         = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = '0;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req.op;
                    key_next    = req.entry_key;
                    amount_next = req.amount;
                    found_next  = 1'b0;
                    cnt_next    = '0;
                    issue_next  = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // issue one slot read a cycle
                if (issue_reg)
                begin
                    mem_re       = 1'b1;
                    d_valid_next = 1'b1;
                    d_idx_next   = cnt_reg;
                    if (cnt_reg == LAST)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                // compare the slot that came back
                if (d_valid_reg)
                begin
                    if (take)
                    begin
                        found_next    = 1'b1;
                        best_next     = mem_rdata;
                        best_idx_next = d_idx_reg;
                    end
                    if (d_idx_reg == LAST)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next               = '0;
                    rsp_next.status        = STATUS_OK;
                    state_next             = S_IDLE;
                    unique case (op_reg)
                        OP_INSERT:
                        begin
                            if (found_reg)
                            begin
                                mem_we        = 1'b1;
                                mem_wdata     = '0;
                                mem_wdata.valid = 1'b1;
                                mem_wdata.id  = key_reg;
                                mem_wdata.pri = amount_reg;
                                mem_wdata.seq = arrival_reg;
                                arrival_next  = arrival_reg + 1'b1;
                            end
                            else
                            begin
                                rsp_next.status = STATUS_FULL;
                            end
                        end
                        OP_INCREASE:
                        begin
                            if (found_reg)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata.pri = pri_sum[PRI_W] ? '1 : pri_sum[PRI_W-1:0];
                            end
                            else
                            begin
                                rsp_next.status = STATUS_MISSING;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (found_reg)
                            begin
                                mem_we          = 1'b1;
                                mem_wdata.valid = 1'b0;
                            end
                            else
                            begin
                                rsp_next.status = STATUS_MISSING;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (found_reg)
                            begin
                                rsp_next.best_key      = best_reg.id;
                                rsp_next.best_priority = best_reg.pri;
                            end
                            else
                            begin
                                rsp_next.status = STATUS_EMPTY;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = STATUS_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            issue_reg     <= 1'b0;
            d_valid_reg   <= 1'b0;
            d_idx_reg     <= '0;
            op_reg        <= OP_INSERT;
            key_reg       <= '0;
            amount_reg    <= '0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
            best_idx_reg  <= '0;
            arrival_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            issue_reg     <= issue_next;
            d_valid_reg   <= d_valid_next;
            d_idx_reg     <= d_idx_next;
            op_reg        <= op_next;
            key_reg       <= key_next;
            amount_reg    <= amount_next;
            found_reg     <= found_next;
            best_reg      <= best_next;
            best_idx_reg  <= best_idx_next;
            arrival_reg   <= arrival_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // the table is written only by the clearing pass or at the end of a request
    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_FINISH))
        else $error("slot memory written outside clear or finish");

    // an accepted request closes the request channel for the scan
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while a scan is running");

    // arrival stamps move only on a successful insert
    a_arrival_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(arrival_reg) |->
            ($past(state_reg) == S_FINISH && $past(op_reg) == OP_INSERT && $past(found_reg)))
        else $error("arrival counter moved outside a successful insert");

    // returned slot data is only consumed during the scan
    a_data_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg |-> (state_reg == S_SCAN))
        else $error("read data pending outside scan");

endmodule

[rtl/core/kpt_mem.sv]
module kpt_mem
    import kpt_pkg::*;
#(
    parameter int DEPTH = ENTRIES_DEF
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  kpt_rec_t                 wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output kpt_rec_t                 rd_data
);

    kpt_rec_t mem_reg [DEPTH];
    kpt_rec_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/kpt_cmp.sv]
module kpt_cmp
    import kpt_pkg::*;
(
    input  kpt_op_t          op,
    input  logic [KEY_W-1:0] key,
    input  kpt_rec_t         cand,
    input  kpt_rec_t         best,
    input  logic             found,
    output logic             take
);

    logic key_hit;
    logic seq_lt;
    logic pri_gt;
    logic pri_eq;

    assign key_hit = (cand.id == key);
    assign seq_lt  = (cand.seq < best.seq);
    assign pri_gt  = (cand.pri > best.pri);
    assign pri_eq  = (cand.pri == best.pri);

    // decide whether the candidate slot replaces the current pick
    always_comb
    begin
        unique case (op)
            OP_INSERT:
                take = !cand.valid && !found;
            OP_INCREASE, OP_REMOVE:
                take = cand.valid && key_hit && (!found || seq_lt);
            OP_QUERY:
                take = cand.valid && (!found || pri_gt || (pri_eq && seq_lt));
            default:
                take = 1'b0;
        endcase
    end

endmodule

[tb/sv/testbench.sv]
module testbench;
    import kpt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TB_ENTRIES = ENTRIES_DEF;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    kpt_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    kpt_rsp_t rsp;

    // idle rates in percent, and a long receiver hold-off in cycles
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int error_count = 0;

    // mirror of the slot table
    logic             slot_used [TB_ENTRIES];
    logic [KEY_W-1:0] slot_key  [TB_ENTRIES];
    logic [PRI_W-1:0] slot_pri  [TB_ENTRIES];
    logic [SEQ_W-1:0] slot_seq  [TB_ENTRIES];
    logic [SEQ_W-1:0] arrival_count;

    // responses the block still owes, oldest first
    kpt_rsp_t owed_rsp [$];

    // keys reused often so that increase and remove find hits
    logic [KEY_W-1:0] key_pool [16];

    keyed_priority_table #(
        .ENTRIES (TB_ENTRIES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // run limit
    initial
    begin
        #5ms;
        $display("keyed_priority_table: mismatch");
        $finish;
    end

    // earliest live slot holding key, -1 if none
    function automatic int earliest_slot(logic [KEY_W-1:0] key);
        int hit;
        hit = -1;
        for (int i = 0; i < TB_ENTRIES; i++)
        begin
            if (slot_used[i] && slot_key[i] == key)
            begin
                if (hit < 0 || slot_seq[i] < slot_seq[hit])
                    hit = i;
            end
        end
        return hit;
    endfunction

    // apply one request to the mirror and return the response it earns
    function automatic kpt_rsp_t table_apply(kpt_req_t r);
        kpt_rsp_t   res;
        int         slot;
        logic [8:0] sum;
        res = '0;
        res.status = STATUS_OK;
        slot = -1;
        case (r.op)
            OP_INSERT:
            begin
                for (int i = 0; i < TB_ENTRIES; i++)
                begin
                    if (!slot_used[i] && slot < 0)
                        slot = i;
                end
                if (slot < 0)
                    res.status = STATUS_FULL;
                else
                begin
                    slot_used[slot] = 1'b1;
                    slot_key[slot] = r.entry_key;
                    slot_pri[slot] = r.amount;
                    slot_seq[slot] = arrival_count;
                    arrival_count = arrival_count + 1;
                end
            end
            OP_INCREASE:
            begin
                slot = earliest_slot(r.entry_key);
                if (slot < 0)
                    res.status = STATUS_MISSING;
                else
                begin
                    sum = {1'b0, slot_pri[slot]} + {1'b0, r.amount};
                    slot_pri[slot] = sum[8] ? 8'hff : sum[7:0];
                end
            end
            OP_REMOVE:
            begin
                slot = earliest_slot(r.entry_key);
                if (slot < 0)
                    res.status = STATUS_MISSING;
                else
                    slot_used[slot] = 1'b0;
            end
            default:
            begin
                for (int i = 0; i < TB_ENTRIES; i++)
                begin
                    if (slot_used[i])
                    begin
                        if (slot < 0 || slot_pri[i] > slot_pri[slot] ||
                            (slot_pri[i] == slot_pri[slot] && slot_seq[i] < slot_seq[slot]))
                            slot = i;
                    end
                end
                if (slot < 0)
                    res.status = STATUS_EMPTY;
                else
                begin
                    res.best_key = slot_key[slot];
                    res.best_priority = slot_pri[slot];
                end
            end
        endcase
        return res;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            error_count++;
        end
    endfunction

    // check responses, then predict newly accepted requests
    always @(posedge clk)
    begin : watch
        kpt_rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (owed_rsp.size() == 0)
                begin
                    $display("%0t: response with none owed, actual %0h", $time, rsp);
                    error_count++;
                end
                else
                begin
                    want = owed_rsp.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp.status));
                    check_field("best_key", want.best_key, rsp.best_key);
                    check_field("best_priority", 32'(want.best_priority),
                                32'(rsp.best_priority));
                end
            end
            if (req_valid && req_ready)
                owed_rsp = {owed_rsp, table_apply(req)};
        end
    end

    // receiver: long hold-off when asked, otherwise random stalls
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp_ready = 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
            rsp_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // offer one request and return at the falling edge after it is taken
    task automatic send_request(kpt_op_t op, logic [KEY_W-1:0] key, logic [PRI_W-1:0] amount);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req.op = op;
        req.entry_key = key;
        req.amount = amount;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        if ($urandom_range(7) == 0)
            return $urandom;
        return key_pool[4'($urandom_range(15))];
    endfunction

    function automatic logic [PRI_W-1:0] random_amount();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic test_empty_table();
        send_request(OP_QUERY, 32'h0, 8'h0);
        send_request(OP_INCREASE, 32'h0, 8'hff);
        send_request(OP_REMOVE, 32'hffff_ffff, 8'h0);
    endtask

    // extreme keys and priorities, ties broken by arrival
    task automatic test_insert_extremes();
        send_request(OP_INSERT, 32'h0, 8'h00);
        send_request(OP_INSERT, 32'hffff_ffff, 8'hff);
        send_request(OP_QUERY, 32'h1234_5678, 8'hff);
        send_request(OP_INSERT, 32'h5555_aaaa, 8'hff);
        send_request(OP_QUERY, 32'h0, 8'h0);
    endtask

    task automatic test_saturation();
        send_request(OP_INCREASE, 32'h0, 8'hff);
        send_request(OP_INCREASE, 32'h0, 8'h01);
        send_request(OP_QUERY, 32'h0, 8'h0);
        send_request(OP_INCREASE, 32'hffff_ffff, 8'h00);
    endtask

    // duplicate keys: increase and remove act on the earliest copy
    task automatic test_duplicate_keys();
        send_request(OP_INSERT, 32'haaaa_5555, 8'h10);
        send_request(OP_INSERT, 32'haaaa_5555, 8'h20);
        send_request(OP_INCREASE, 32'haaaa_5555, 8'hf5);
        send_request(OP_REMOVE, 32'h0, 8'h0);
        send_request(OP_REMOVE, 32'hffff_ffff, 8'h0);
        send_request(OP_REMOVE, 32'h5555_aaaa, 8'h0);
        send_request(OP_QUERY, 32'h0, 8'h0);
        send_request(OP_REMOVE, 32'haaaa_5555, 8'h0);
        send_request(OP_QUERY, 32'h0, 8'h0);
        send_request(OP_REMOVE, 32'haaaa_5555, 8'h0);
        send_request(OP_REMOVE, 32'haaaa_5555, 8'h0);
        send_request(OP_QUERY, 32'h0, 8'h0);
    endtask

    // fill every slot, overflow twice, then reuse a freed slot
    task automatic test_full_table();
        for (int i = 0; i <= TB_ENTRIES; i++)
            send_request(OP_INSERT, random_key(), random_amount());
        send_request(OP_INSERT, 32'hdead_0001, 8'h7f);
        send_request(OP_QUERY, 32'h0, 8'h0);
        send_request(OP_REMOVE, key_pool[4'($urandom_range(15))], 8'h0);
        send_request(OP_INSERT, 32'hdead_0002, 8'hff);
        send_request(OP_QUERY, 32'h0, 8'h0);
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        hold_cycles = 6 * (TB_ENTRIES + 3);
        for (int i = 0; i < 8; i++)
        begin
            if (i[0])
                send_request(OP_QUERY, 32'h0, 8'h0);
            else
                send_request(OP_REMOVE, random_key(), 8'h0);
        end
    endtask

    task automatic test_random_mix(int count, int send_pct, int recv_pct,
                                   int insert_w, int remove_w);
        int roll;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < insert_w)
                send_request(OP_INSERT, random_key(), random_amount());
            else if (roll < insert_w + remove_w)
                send_request(OP_REMOVE, random_key(), random_amount());
            else if (roll < insert_w + remove_w + 25)
                send_request(OP_INCREASE, random_key(), random_amount());
            else
                send_request(OP_QUERY, $urandom, random_amount());
        end
    endtask

    // reset, then the tests in turn
    initial
    begin
        for (int i = 0; i < TB_ENTRIES; i++)
        begin
            slot_used[i] = 1'b0;
            slot_key[i] = '0;
            slot_pri[i] = '0;
            slot_seq[i] = '0;
        end
        arrival_count = '0;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hffff_ffff;
        for (int i = 2; i < 16; i++)
            key_pool[i] = $urandom;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 19;
        recv_idle_pct = 58;
        test_empty_table();
        test_insert_extremes();
        test_saturation();
        test_duplicate_keys();
        test_full_table();
        test_backpressure();
        test_random_mix(216, 19, 58, 45, 15);
        test_random_mix(216, 58, 19, 15, 45);
        test_random_mix(216, 0, 0, 30, 25);
        req_valid = 1'b0;

        // drain, then allow one more scan for stray responses
        while (owed_rsp.size() != 0)
            @(posedge clk);
        repeat (TB_ENTRIES + 8) @(posedge clk);

        if (error_count == 0)
            $display("keyed_priority_table: match");
        else
            $display("keyed_priority_table: mismatch");
        $finish;
    end

endmodule
